// ===== design/itch_mfd_pkg.sv =====
// ----------------------------------------------------------------------------
// itch_mfd_pkg
// Shared types and constants of the ITCH 5.0 message field decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package itch_mfd_pkg;

    localparam int BufDepth = 44;
    localparam int CountW   = 6;

    localparam logic [CountW-1:0] CountMax = 6'h3F;

    // Byte 0 of the buffer sits at the most significant end, so an
    // ascending slice reads a big-endian field directly.
    typedef logic [0:BufDepth-1][7:0] msg_buf_t;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
    localparam logic [1:0] STATUS_SHORT   = 2'd2;

    localparam logic [7:0] TYPE_S = 8'h53;
    localparam logic [7:0] TYPE_R = 8'h52;
    localparam logic [7:0] TYPE_A = 8'h41;
    localparam logic [7:0] TYPE_F = 8'h46;
    localparam logic [7:0] TYPE_E = 8'h45;
    localparam logic [7:0] TYPE_C = 8'h43;
    localparam logic [7:0] TYPE_X = 8'h58;
    localparam logic [7:0] TYPE_D = 8'h44;
    localparam logic [7:0] TYPE_U = 8'h55;
    localparam logic [7:0] TYPE_P = 8'h50;

    typedef struct packed {
        logic              valid;
        logic [CountW-1:0] len;
    } pend_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  message_type;
        logic [15:0] locate_id;
        logic [15:0] track_id;
        logic [47:0] timestamp;
        logic [63:0] reference_a;
        logic [63:0] reference_b;
        logic [31:0] quantity;
        logic [31:0] price_word;
        logic [63:0] symbol;
        logic [63:0] chars_low;
        logic [31:0] chars_high;
    } record_t;

endpackage

`default_nettype wire

// ===== design/itch_mfd_capture.sv =====
// ----------------------------------------------------------------------------
// itch_mfd_capture
// Stores the leading message bytes, counts bytes and holds a finished
// message until the decode stage can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module itch_mfd_capture (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  last_byte,
    input  wire logic                  advance,
    output itch_mfd_pkg::pend_t        pend,
    output itch_mfd_pkg::msg_buf_t     buf_data
);

    logic [itch_mfd_pkg::CountW-1:0] count_reg;
    logic [itch_mfd_pkg::CountW-1:0] count_next;
    logic [itch_mfd_pkg::CountW-1:0] count_inc;
    logic                            pend_reg;
    logic                            pend_next;
    logic [itch_mfd_pkg::CountW-1:0] len_reg;
    logic [itch_mfd_pkg::CountW-1:0] len_next;
    itch_mfd_pkg::msg_buf_t          buf_reg;
    itch_mfd_pkg::msg_buf_t          buf_next;
    logic                            accept;

    // Hold new bytes while a finished message still waits for decode.
    assign in_stall = pend_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign count_inc = (count_reg == itch_mfd_pkg::CountMax) ?
                       count_reg : count_reg + 6'd1;

    always_comb
    begin
        count_next = count_reg;
        len_next   = len_reg;
        buf_next   = buf_reg;
        pend_next  = pend_reg && !advance;
        if (accept)
        begin
            if (count_reg < 6'(itch_mfd_pkg::BufDepth))
            begin
                buf_next[count_reg] = data_byte;
            end
            if (last_byte)
            begin
                count_next = '0;
                len_next   = count_inc;
                pend_next  = 1'b1;
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        buf_reg <= buf_next;
    end

    assign pend.valid = pend_reg;
    assign pend.len   = len_reg;
    assign buf_data   = buf_reg;

endmodule

`default_nettype wire

// ===== design/itch_mfd_decode.sv =====
// ----------------------------------------------------------------------------
// itch_mfd_decode
// Maps the buffered bytes of one message onto the shared record slots.
// ----------------------------------------------------------------------------
`default_nettype none

module itch_mfd_decode (
    input  wire itch_mfd_pkg::msg_buf_t          buf_data,
    input  wire logic [itch_mfd_pkg::CountW-1:0] len,
    output itch_mfd_pkg::record_t                rec
);

    logic [7:0]                      msg_type;
    logic [itch_mfd_pkg::CountW-1:0] need;

    assign msg_type = buf_data[0];

    always_comb
    begin
        unique case (msg_type)
            itch_mfd_pkg::TYPE_S: need = 6'd12;
            itch_mfd_pkg::TYPE_R: need = 6'd39;
            itch_mfd_pkg::TYPE_A: need = 6'd36;
            itch_mfd_pkg::TYPE_F: need = 6'd40;
            itch_mfd_pkg::TYPE_E: need = 6'd31;
            itch_mfd_pkg::TYPE_C: need = 6'd36;
            itch_mfd_pkg::TYPE_X: need = 6'd23;
            itch_mfd_pkg::TYPE_D: need = 6'd19;
            itch_mfd_pkg::TYPE_U: need = 6'd35;
            itch_mfd_pkg::TYPE_P: need = 6'd44;
            default:              need = 6'd0;
        endcase
    end

    always_comb
    begin
        rec = '0;
        if (need == 6'd0)
        begin
            rec.status = itch_mfd_pkg::STATUS_UNKNOWN;
        end
        else if (len < need)
        begin
            rec.status = itch_mfd_pkg::STATUS_SHORT;
        end
        else
        begin
            rec.status       = itch_mfd_pkg::STATUS_OK;
            rec.message_type = msg_type;
            rec.locate_id    = buf_data[1:2];
            rec.track_id     = buf_data[3:4];
            rec.timestamp    = buf_data[5:10];
            unique case (msg_type)
                itch_mfd_pkg::TYPE_S:
                begin
                    rec.chars_low = {56'd0, buf_data[11]};
                end
                itch_mfd_pkg::TYPE_R:
                begin
                    rec.symbol     = buf_data[11:18];
                    rec.quantity   = buf_data[21:24];
                    rec.price_word = buf_data[34:37];
                    rec.chars_low  = {buf_data[19:20], buf_data[25:30]};
                    rec.chars_high = {buf_data[31:33], buf_data[38]};
                end
                itch_mfd_pkg::TYPE_A, itch_mfd_pkg::TYPE_F, itch_mfd_pkg::TYPE_P:
                begin
                    rec.reference_a = buf_data[11:18];
                    rec.chars_low   = {56'd0, buf_data[19]};
                    rec.quantity    = buf_data[20:23];
                    rec.symbol      = buf_data[24:31];
                    rec.price_word  = buf_data[32:35];
                    if (msg_type == itch_mfd_pkg::TYPE_F)
                    begin
                        rec.chars_high = buf_data[36:39];
                    end
                    if (msg_type == itch_mfd_pkg::TYPE_P)
                    begin
                        rec.reference_b = buf_data[36:43];
                    end
                end
                itch_mfd_pkg::TYPE_E, itch_mfd_pkg::TYPE_C:
                begin
                    rec.reference_a = buf_data[11:18];
                    rec.quantity    = buf_data[19:22];
                    rec.reference_b = buf_data[23:30];
                    if (msg_type == itch_mfd_pkg::TYPE_C)
                    begin
                        rec.chars_low  = {56'd0, buf_data[31]};
                        rec.price_word = buf_data[32:35];
                    end
                end
                itch_mfd_pkg::TYPE_X:
                begin
                    rec.reference_a = buf_data[11:18];
                    rec.quantity    = buf_data[19:22];
                end
                itch_mfd_pkg::TYPE_D:
                begin
                    rec.reference_a = buf_data[11:18];
                end
                itch_mfd_pkg::TYPE_U:
                begin
                    rec.reference_a = buf_data[11:18];
                    rec.reference_b = buf_data[19:26];
                    rec.quantity    = buf_data[27:30];
                    rec.price_word  = buf_data[31:34];
                end
                default:
                begin
                    rec.message_type = msg_type;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/itch_message_field_decoder_top.sv =====
// ----------------------------------------------------------------------------
// itch_message_field_decoder_top
// ITCH 5.0 message decoder: byte stream in, one decoded record per message.
// ----------------------------------------------------------------------------
// Input channel: one message byte per transfer (data_byte), with last_byte
// set on the final byte of a message. Output channel: one record per
// message, carrying status and the decoded fields as separate ports.
// A transfer happens on a rising edge with valid high and stall low.
// Throughput: one byte per cycle, sustained, including back-to-back
// messages, as long as in_stall stays low. A record appears on out_valid
// once the finished message has been registered in the capture stage and
// a single combinational decode pass over the 44-byte capture buffer has
// loaded the output register; out_stall can hold it in the capture stage.
// Stalls: while out_stall holds a record, one more finished message is
// held in the capture stage; only then does in_stall rise, and it drops
// as soon as the output register frees up.
// Reset: clears the byte count and both valid flags; buffer contents are
// not cleared and are only read after being written by the current message.
// ----------------------------------------------------------------------------
`default_nettype none

module itch_message_field_decoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [7:0]       message_type,
    output logic [15:0]      locate_id,
    output logic [15:0]      track_id,
    output logic [47:0]      timestamp,
    output logic [63:0]      reference_a,
    output logic [63:0]      reference_b,
    output logic [31:0]      quantity,
    output logic [31:0]      price_word,
    output logic [63:0]      symbol,
    output logic [63:0]      chars_low,
    output logic [31:0]      chars_high
);

    itch_mfd_pkg::pend_t    pend;
    itch_mfd_pkg::msg_buf_t buf_data;
    itch_mfd_pkg::record_t  rec;
    itch_mfd_pkg::record_t  rec_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   advance;

    assign advance = !out_valid_reg || !out_stall;

    itch_mfd_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .advance   (advance),
        .pend      (pend),
        .buf_data  (buf_data)
    );

    itch_mfd_decode u_decode (
        .buf_data (buf_data),
        .len      (pend.len),
        .rec      (rec)
    );

    assign out_valid_next = advance ? pend.valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load a new record only when the previous one has left.
    always_ff @(posedge clk)
    begin
        if (advance && pend.valid)
        begin
            rec_reg <= rec;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = rec_reg.status;
    assign message_type = rec_reg.message_type;
    assign locate_id    = rec_reg.locate_id;
    assign track_id     = rec_reg.track_id;
    assign timestamp    = rec_reg.timestamp;
    assign reference_a  = rec_reg.reference_a;
    assign reference_b  = rec_reg.reference_b;
    assign quantity     = rec_reg.quantity;
    assign price_word   = rec_reg.price_word;
    assign symbol       = rec_reg.symbol;
    assign chars_low    = rec_reg.chars_low;
    assign chars_high   = rec_reg.chars_high;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stand-alone testbench for the ITCH 5.0 message field decoder.
// ----------------------------------------------------------------------------
// Bytes go in one transfer at a time with random gaps. Records come out
// against random output stalls. A shadow copy of the capture buffer and the
// byte count predicts each record, and every record is checked field by
// field against the oldest prediction. Directed tests cover every message
// type, field extremes, short, unknown and over-long messages. Random
// traffic follows them, mostly well-formed messages with some noise mixed in.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    localparam int RandomBytes   = 300;
    localparam int RandomRecords = 10;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [7:0]  message_type;
    logic [15:0] locate_id;
    logic [15:0] track_id;
    logic [47:0] timestamp;
    logic [63:0] reference_a;
    logic [63:0] reference_b;
    logic [31:0] quantity;
    logic [31:0] price_word;
    logic [63:0] symbol;
    logic [63:0] chars_low;
    logic [31:0] chars_high;

    // Shadow of the capture state, updated on every input transfer
    logic [7:0]                      shadow_buf [0:itch_mfd_pkg::BufDepth-1];
    logic [itch_mfd_pkg::CountW-1:0] shadow_count;
    itch_mfd_pkg::record_t           pending_records [$];

    logic [7:0] known_types [10] = '{
        itch_mfd_pkg::TYPE_S, itch_mfd_pkg::TYPE_R, itch_mfd_pkg::TYPE_A,
        itch_mfd_pkg::TYPE_F, itch_mfd_pkg::TYPE_E, itch_mfd_pkg::TYPE_C,
        itch_mfd_pkg::TYPE_X, itch_mfd_pkg::TYPE_D, itch_mfd_pkg::TYPE_U,
        itch_mfd_pkg::TYPE_P};

    bit idle_on;
    int error_count;
    int bytes_sent;
    int records_seen;
    int decoded_count;
    int unknown_count;
    int short_count;

    itch_message_field_decoder_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .message_type (message_type),
        .locate_id    (locate_id),
        .track_id     (track_id),
        .timestamp    (timestamp),
        .reference_a  (reference_a),
        .reference_b  (reference_b),
        .quantity     (quantity),
        .price_word   (price_word),
        .symbol       (symbol),
        .chars_low    (chars_low),
        .chars_high   (chars_high)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("timeout: run did not finish");
        $display("tb NOT OK");
        $finish;
    end

    function automatic int wire_bytes(input logic [7:0] kind);
        case (kind)
            itch_mfd_pkg::TYPE_S: return 12;
            itch_mfd_pkg::TYPE_R: return 39;
            itch_mfd_pkg::TYPE_A: return 36;
            itch_mfd_pkg::TYPE_F: return 40;
            itch_mfd_pkg::TYPE_E: return 31;
            itch_mfd_pkg::TYPE_C: return 36;
            itch_mfd_pkg::TYPE_X: return 23;
            itch_mfd_pkg::TYPE_D: return 19;
            itch_mfd_pkg::TYPE_U: return 35;
            itch_mfd_pkg::TYPE_P: return 44;
            default:              return 0;
        endcase
    endfunction

    function automatic logic [63:0] be_field(input int pos, input int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++)
            v = {v[55:0], shadow_buf[pos + i]};
        return v;
    endfunction

    function automatic itch_mfd_pkg::record_t decode_record(
        input logic [itch_mfd_pkg::CountW-1:0] len);
        itch_mfd_pkg::record_t r;
        logic [7:0]            kind;
        int                    need;
        r    = '0;
        kind = shadow_buf[0];
        need = wire_bytes(kind);
        if (need == 0)
        begin
            r.status = itch_mfd_pkg::STATUS_UNKNOWN;
            return r;
        end
        if (int'(len) < need)
        begin
            r.status = itch_mfd_pkg::STATUS_SHORT;
            return r;
        end
        r.status       = itch_mfd_pkg::STATUS_OK;
        r.message_type = kind;
        r.locate_id    = 16'(be_field(1, 2));
        r.track_id     = 16'(be_field(3, 2));
        r.timestamp    = 48'(be_field(5, 6));
        case (kind)
            itch_mfd_pkg::TYPE_S:
            begin
                r.chars_low = {56'd0, shadow_buf[11]};
            end
            itch_mfd_pkg::TYPE_R:
            begin
                r.symbol     = be_field(11, 8);
                r.quantity   = 32'(be_field(21, 4));
                r.price_word = 32'(be_field(34, 4));
                r.chars_low  = {shadow_buf[19], shadow_buf[20], shadow_buf[25],
                                shadow_buf[26], shadow_buf[27], shadow_buf[28],
                                shadow_buf[29], shadow_buf[30]};
                r.chars_high = {shadow_buf[31], shadow_buf[32], shadow_buf[33],
                                shadow_buf[38]};
            end
            itch_mfd_pkg::TYPE_A, itch_mfd_pkg::TYPE_F, itch_mfd_pkg::TYPE_P:
            begin
                r.reference_a = be_field(11, 8);
                r.chars_low   = {56'd0, shadow_buf[19]};
                r.quantity    = 32'(be_field(20, 4));
                r.symbol      = be_field(24, 8);
                r.price_word  = 32'(be_field(32, 4));
                if (kind == itch_mfd_pkg::TYPE_F)
                    r.chars_high = 32'(be_field(36, 4));
                if (kind == itch_mfd_pkg::TYPE_P)
                    r.reference_b = be_field(36, 8);
            end
            itch_mfd_pkg::TYPE_E, itch_mfd_pkg::TYPE_C:
            begin
                r.reference_a = be_field(11, 8);
                r.quantity    = 32'(be_field(19, 4));
                r.reference_b = be_field(23, 8);
                if (kind == itch_mfd_pkg::TYPE_C)
                begin
                    r.chars_low  = {56'd0, shadow_buf[31]};
                    r.price_word = 32'(be_field(32, 4));
                end
            end
            itch_mfd_pkg::TYPE_X:
            begin
                r.reference_a = be_field(11, 8);
                r.quantity    = 32'(be_field(19, 4));
            end
            itch_mfd_pkg::TYPE_D:
            begin
                r.reference_a = be_field(11, 8);
            end
            itch_mfd_pkg::TYPE_U:
            begin
                r.reference_a = be_field(11, 8);
                r.reference_b = be_field(19, 8);
                r.quantity    = 32'(be_field(27, 4));
                r.price_word  = 32'(be_field(31, 4));
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < 40)
            $display("mismatch on record %0d, %s: got %h, expected %h",
                     records_seen, what, got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic check_record(input itch_mfd_pkg::record_t want);
        check_field("status",       64'(status),       64'(want.status));
        check_field("message_type", 64'(message_type), 64'(want.message_type));
        check_field("locate_id",    64'(locate_id),    64'(want.locate_id));
        check_field("track_id",     64'(track_id),     64'(want.track_id));
        check_field("timestamp",    64'(timestamp),    64'(want.timestamp));
        check_field("reference_a",  reference_a,       want.reference_a);
        check_field("reference_b",  reference_b,       want.reference_b);
        check_field("quantity",     64'(quantity),     64'(want.quantity));
        check_field("price_word",   64'(price_word),   64'(want.price_word));
        check_field("symbol",       symbol,            want.symbol);
        check_field("chars_low",    chars_low,         want.chars_low);
        check_field("chars_high",   64'(chars_high),   64'(want.chars_high));
        case (want.status)
            itch_mfd_pkg::STATUS_OK:      decoded_count++;
            itch_mfd_pkg::STATUS_UNKNOWN: unknown_count++;
            default:                      short_count++;
        endcase
    endtask

    // Check output transfers first: a record never leaves in the cycle its
    // last byte goes in, so the queue order stays right.
    always @(posedge clk)
    begin : record_monitor
        itch_mfd_pkg::record_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_records.size() == 0)
                    report_mismatch("record with nothing pending", 64'(status), '0);
                else
                begin
                    want = pending_records.pop_front();
                    check_record(want);
                end
                records_seen++;
            end
            if (in_valid && !in_stall)
            begin
                if (shadow_count < itch_mfd_pkg::BufDepth)
                    shadow_buf[shadow_count] = data_byte;
                if (shadow_count != itch_mfd_pkg::CountMax)
                    shadow_count++;
                if (last_byte)
                begin
                    pending_records.push_back(decode_record(shadow_count));
                    shadow_count = '0;
                end
            end
        end
    end

    // Receiver: hold stall for a random number of cycles before each record
    initial
    begin : record_sink
        int unsigned hold;
        out_stall <= 1'b0;
        forever
        begin
            hold = idle_on ? $urandom_range(0, 6) : 0;
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic final_byte);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        last_byte <= final_byte;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    task automatic send_message(input logic [7:0] kind, input int len, input int fill);
        logic [7:0] value;
        for (int i = 0; i < len; i++)
        begin
            if (i == 0)
                value = kind;
            else
                case (fill)
                    FILL_ZERO: value = 8'h00;
                    FILL_ONES: value = 8'hFF;
                    default:   value = 8'($urandom);
                endcase
            send_byte(value, i == len - 1);
        end
    endtask

    // Hold the sender until every predicted record has been checked
    task automatic wait_for_records();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_records.size() != 0);
    endtask

    task automatic test_each_type();
        idle_on = 1'b0;
        foreach (known_types[k])
            send_message(known_types[k], wire_bytes(known_types[k]), FILL_RANDOM);
        wait_for_records();
    endtask

    task automatic test_field_extremes();
        idle_on = 1'b1;
        send_message(itch_mfd_pkg::TYPE_P, 44, FILL_ONES);
        send_message(itch_mfd_pkg::TYPE_P, 44, FILL_ZERO);
        send_message(itch_mfd_pkg::TYPE_R, 39, FILL_ONES);
        send_message(itch_mfd_pkg::TYPE_F, 40, FILL_ONES);
        wait_for_records();
    endtask

    task automatic test_short_messages();
        send_message(itch_mfd_pkg::TYPE_S, 11, FILL_RANDOM);
        send_message(itch_mfd_pkg::TYPE_P, 43, FILL_ONES);
        send_message(itch_mfd_pkg::TYPE_D, 18, FILL_RANDOM);
        send_message(itch_mfd_pkg::TYPE_R, 1, FILL_RANDOM);
        wait_for_records();
    endtask

    task automatic test_unknown_types();
        send_message(8'h00, 1, FILL_RANDOM);
        send_message(8'hFF, 50, FILL_RANDOM);
        wait_for_records();
    endtask

    // Past 63 bytes the count saturates; extra bytes must not disturb the record
    task automatic test_long_messages();
        send_message(itch_mfd_pkg::TYPE_F, 80, FILL_RANDOM);
        send_message(itch_mfd_pkg::TYPE_D, 45, FILL_RANDOM);
        send_message(itch_mfd_pkg::TYPE_S, 64, FILL_ONES);
        wait_for_records();
    endtask

    task automatic test_random_traffic();
        int         start_bytes;
        int         start_records;
        int         pick;
        int         need;
        int         len;
        int         fill;
        logic [7:0] kind;
        start_bytes   = bytes_sent;
        start_records = records_seen;
        while (bytes_sent - start_bytes < RandomBytes ||
               records_seen - start_records + pending_records.size() < RandomRecords)
        begin
            if ($urandom_range(0, 7) == 0)
                idle_on = ~idle_on;
            kind = known_types[$urandom_range(0, 9)];
            need = wire_bytes(kind);
            fill = ($urandom_range(0, 9) == 0) ? FILL_ONES : FILL_RANDOM;
            pick = $urandom_range(0, 99);
            if (pick < 50)
                len = need;
            else if (pick < 65)
                len = need + $urandom_range(1, 30);
            else if (pick < 80)
                len = $urandom_range(1, need - 1);
            else if (pick < 90)
            begin
                do kind = 8'($urandom); while (wire_bytes(kind) != 0);
                len = $urandom_range(1, 50);
            end
            else
            begin
                kind = 8'($urandom);
                len  = $urandom_range(1, 70);
            end
            send_message(kind, len, fill);
            if ($urandom_range(0, 19) == 0)
                wait_for_records();
        end
        wait_for_records();
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        data_byte    <= 8'h00;
        last_byte    <= 1'b0;
        shadow_count  = '0;
        idle_on       = 1'b1;
        error_count   = 0;
        bytes_sent    = 0;
        records_seen  = 0;
        decoded_count = 0;
        unknown_count = 0;
        short_count   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_each_type();
        test_field_extremes();
        test_short_messages();
        test_unknown_types();
        test_long_messages();
        test_random_traffic();

        repeat (10) @(posedge clk);
        $display("covered %0d bytes in, %0d records out", bytes_sent, records_seen);
        $display("records: %0d decoded, %0d unknown type, %0d short; %0d mismatches",
                 decoded_count, unknown_count, short_count, error_count);
        if (error_count == 0 && pending_records.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
